// ===== design/csm_pkg.sv =====
// Shared types, constants and a helper function for the clamped position smoother.
package csm_pkg;

   // Field widths
   localparam int COORD_W    = 24;
   localparam int PIX_W      = 16;
   localparam int VIEW_W     = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Default history depth
   localparam int HISTORY_DEPTH_DEF = 32;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PIX_W-1:0]   pix_type;
   typedef logic        [VIEW_W-1:0]  view_type;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BOUND_LEFT   = 3'd0,
      REG_BOUND_RIGHT  = 3'd1,
      REG_BOUND_TOP    = 3'd2,
      REG_BOUND_BOTTOM = 3'd3,
      REG_VIEW_WIDTH   = 3'd4,
      REG_VIEW_HEIGHT  = 3'd5
   } csr_index_type;

   // Sum of tap weights max(i+1, depth-i) over the history, elaboration only
   function automatic int weight_sum(input int depth);
      int acc;
      acc = 0;
      for (int i = 0; i < depth; i++) begin
         acc += ((i + 1) > (depth - i)) ? (i + 1) : (depth - i);
      end
      return acc;
   endfunction

endpackage

// ===== design/csm_req_if.sv =====
// Request channel: target position with valid/ready handshake.
interface csm_req_if
   import csm_pkg::*;
();
   logic      valid;
   logic      ready;
   coord_type target_x;
   coord_type target_y;

   modport source (output valid, output target_x, output target_y, input ready);
   modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

// ===== design/csm_rsp_if.sv =====
// Response channel: new and previous smoothed positions with valid/ready handshake.
interface csm_rsp_if
   import csm_pkg::*;
();
   logic      valid;
   logic      ready;
   coord_type center_x;
   coord_type center_y;
   coord_type previous_x;
   coord_type previous_y;

   modport source (output valid, output center_x, output center_y,
                   output previous_x, output previous_y, input ready);
   modport sink   (input valid, input center_x, input center_y,
                   input previous_x, input previous_y, output ready);
endinterface

// ===== design/csm_csr_if.sv =====
// Configuration write channel: register index and data with valid/ready handshake.
interface csm_csr_if
   import csm_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/clamped_position_smoother_unit.sv =====
// Clamped position smoother: bound clamp, history RAM and weighted-mean filter.
//
// Usage: each request on req_port carries one target position (signed Q16.8).
// The position is clamped per axis to the bound rectangle less the view size,
// pushed into a HISTORY_DEPTH-entry history RAM, and the weighted mean of the
// history (weights max(i+1, HISTORY_DEPTH-i), newest first) goes out on
// rsp_port together with the smoothed position of the previous request.
// csr_port writes the bound and view registers and is always ready. Write it
// only while no request is in flight; the block does not enforce this.
// The first request after reset fills the whole history RAM, one entry per
// cycle, and then answers. Every later request makes one RAM read per cycle
// through the single read port over all entries plus a three-stage pipeline
// drain, then a reciprocal multiply for the divide by twice the constant
// weight sum, a remainder and one correction step. One request is processed
// at a time; the next one is accepted the cycle after the response is loaded.
// Reset clears the control, output and bound/view registers, the output valid
// and the primed flag, but not the payload registers; the RAM holds garbage
// until the first request fills it.
// A stalled response holds in the output register; the next request is
// still accepted and processed, and only its completion waits for the slot.
module clamped_position_smoother_unit
   import csm_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   csm_req_if.sink   req_port,
   csm_rsp_if.source rsp_port,
   csm_csr_if.sink   csr_port
);

   // Derived sizes
   localparam int IDX_W  = $clog2(HISTORY_DEPTH);
   localparam int W_W    = $clog2(HISTORY_DEPTH + 1);
   localparam int WSUM   = weight_sum(HISTORY_DEPTH);
   localparam int PROD_W = COORD_W + W_W + 1;
   localparam int ACC_W  = COORD_W + $clog2(WSUM + 1);
   localparam int N_W    = ACC_W + 1;
   localparam int STEP_W = 2;
   localparam int ENT_W  = 2 * COORD_W;

   // Constant divide by twice the weight sum through a scaled reciprocal
   localparam int                 DIV_D   = 2 * WSUM;
   localparam int                 REM_W   = $clog2(DIV_D + 1) + 1;
   localparam longint             RECIP   = (longint'(1) << N_W) / longint'(DIV_D);
   localparam int                 RCP_W   = $clog2(RECIP + 1);
   localparam int                 MUL_W   = N_W + RCP_W;
   localparam logic [RCP_W-1:0]   RECIP_C = RCP_W'(RECIP);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_CLAMP   = 8'b0000_0010,
      S_FILL    = 8'b0000_0100,
      S_WRITE   = 8'b0000_1000,
      S_READ    = 8'b0001_0000,
      S_DIVLOAD = 8'b0010_0000,
      S_DIV     = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   // Configuration registers
   pix_type  bound_left_ff, bound_right_ff, bound_top_ff, bound_bottom_ff;
   view_type view_width_ff, view_height_ff;

   // Control
   state_type        state_ff, state_in;
   logic             primed_ff, primed_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [IDX_W:0]   cnt_ff, cnt_in;
   logic             rv_ff, rv_in;
   logic             pv_ff, pv_in;
   logic [IDX_W-1:0] widx_ff, widx_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Datapath
   coord_type                tx_ff, tx_in, ty_ff, ty_in;
   coord_type                px_ff, px_in, py_ff, py_in;
   logic [ENT_W-1:0]         rdata_ff;
   logic signed [PROD_W-1:0] prodx_ff, prodx_in, prody_ff, prody_in;
   logic signed [ACC_W-1:0]  accx_ff, accx_in, accy_ff, accy_in;
   logic                     negx_ff, negx_in, negy_ff, negy_in;
   logic [REM_W-1:0]         remx_ff, remx_in, remy_ff, remy_in;
   logic [COORD_W-1:0]       quox_ff, quox_in, quoy_ff, quoy_in;
   coord_type                curx_ff, curx_in, cury_ff, cury_in;
   coord_type                prvx_ff, prvx_in, prvy_ff, prvy_in;

   // History RAM
   logic [ENT_W-1:0] hist_ram [HISTORY_DEPTH];
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;

   // Combinational helpers
   logic [IDX_W-1:0]   slot_dec, addr_inc;
   logic               issue;
   logic [W_W-1:0]     wgt;
   logic [ACC_W-1:0]   magx, magy;
   logic [N_W-1:0]     numx, numy;
   logic [MUL_W-1:0]   recx, recy;
   logic [N_W-1:0]     diffx, diffy;
   logic               out_free;

   // Clamp one axis of a Q16.8 coordinate to the allowed range
   function automatic coord_type clamp_axis(input coord_type v, input pix_type lo,
                                            input pix_type hi, input view_type view);
      logic signed [PIX_W:0] diff, sum, a17, b17;
      view_type              half, rest;
      coord_type             a24, b24, mid24, res;
      diff  = (PIX_W+1)'(hi) - (PIX_W+1)'(lo);
      sum   = (PIX_W+1)'(lo) + (PIX_W+1)'(hi);
      half  = view >> 1;
      rest  = view - half;
      a17   = (PIX_W+1)'(lo) + $signed({2'b00, half});
      b17   = (PIX_W+1)'(hi) - $signed({2'b00, rest});
      a24   = {a17[PIX_W-1:0], 8'h00};
      b24   = {b17[PIX_W-1:0], 8'h00};
      mid24 = {sum[PIX_W:1], 8'h00};
      if (diff <= $signed({2'b00, view})) begin
         res = mid24;
      end else if (v < a24) begin
         res = a24;
      end else if (v > b24) begin
         res = b24;
      end else begin
         res = v;
      end
      return res;
   endfunction

   // Tap weight max(i+1, depth-i)
   function automatic logic [W_W-1:0] weight_of(input logic [IDX_W-1:0] idx);
      logic [W_W-1:0] up, dn;
      up = W_W'(idx) + W_W'(1);
      dn = W_W'(HISTORY_DEPTH) - W_W'(idx);
      return (up > dn) ? up : dn;
   endfunction

   // Port drive
   assign req_port.ready    = (state_ff == S_IDLE);
   assign csr_port.ready    = 1'b1;
   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.center_x   = curx_ff;
   assign rsp_port.center_y   = cury_ff;
   assign rsp_port.previous_x = prvx_ff;
   assign rsp_port.previous_y = prvy_ff;

   // Address arithmetic with wrap at the history depth
   assign slot_dec = (slot_ff == '0) ? IDX_W'(HISTORY_DEPTH - 1) : slot_ff - IDX_W'(1);
   assign addr_inc = (addr_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : addr_ff + IDX_W'(1);
   assign issue    = (cnt_ff < (IDX_W+1)'(HISTORY_DEPTH));
   assign wgt      = weight_of(widx_ff);

   // Divider operands: rounded magnitude (2|acc| + W) over 2W
   assign magx  = accx_ff[ACC_W-1] ? ACC_W'(-accx_ff) : ACC_W'(accx_ff);
   assign magy  = accy_ff[ACC_W-1] ? ACC_W'(-accy_ff) : ACC_W'(accy_ff);
   assign numx  = {magx, 1'b0} + N_W'(WSUM);
   assign numy  = {magy, 1'b0} + N_W'(WSUM);
   // quotient estimate is exact or one low
   assign recx  = MUL_W'(numx) * MUL_W'(RECIP_C);
   assign recy  = MUL_W'(numy) * MUL_W'(RECIP_C);
   assign diffx = numx - N_W'(quox_ff) * N_W'(DIV_D);
   assign diffy = numy - N_W'(quoy_ff) * N_W'(DIV_D);

   assign out_free  = !rsp_valid_ff || rsp_port.ready;
   assign mem_we    = (state_ff == S_FILL) || (state_ff == S_WRITE);
   assign mem_waddr = (state_ff == S_FILL) ? addr_ff : slot_dec;

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      primed_in    = primed_ff;
      slot_in      = slot_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      rv_in        = 1'b0;
      pv_in        = 1'b0;
      widx_in      = widx_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      prodx_in     = PROD_W'($signed(rdata_ff[COORD_W-1:0])) *
                     PROD_W'($signed({1'b0, wgt}));
      prody_in     = PROD_W'($signed(rdata_ff[ENT_W-1:COORD_W])) *
                     PROD_W'($signed({1'b0, wgt}));
      accx_in      = accx_ff;
      accy_in      = accy_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      remx_in      = remx_ff;
      remy_in      = remy_ff;
      quox_in      = quox_ff;
      quoy_in      = quoy_ff;
      curx_in      = curx_ff;
      cury_in      = cury_ff;
      prvx_in      = prvx_ff;
      prvy_in      = prvy_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_port.valid) begin
               tx_in    = req_port.target_x;
               ty_in    = req_port.target_y;
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            px_in   = clamp_axis(tx_ff, bound_left_ff, bound_right_ff, view_width_ff);
            py_in   = clamp_axis(ty_ff, bound_top_ff, bound_bottom_ff, view_height_ff);
            addr_in = '0;
            cnt_in  = '0;
            state_in = primed_ff ? S_WRITE : S_FILL;
         end
         S_FILL: begin
            // write the clamped point into every entry
            addr_in = addr_inc;
            cnt_in  = cnt_ff + (IDX_W+1)'(1);
            if (cnt_ff == (IDX_W+1)'(HISTORY_DEPTH - 1)) begin
               slot_in  = '0;
               state_in = S_DONE;
            end
         end
         S_WRITE: begin
            // newest entry goes one slot back; sweep starts there
            slot_in  = slot_dec;
            addr_in  = slot_dec;
            cnt_in   = '0;
            accx_in  = '0;
            accy_in  = '0;
            state_in = S_READ;
         end
         S_READ: begin
            // read, weight, accumulate pipeline
            rv_in   = issue;
            pv_in   = rv_ff;
            widx_in = cnt_ff[IDX_W-1:0];
            if (issue) begin
               addr_in = addr_inc;
               cnt_in  = cnt_ff + (IDX_W+1)'(1);
            end
            if (pv_ff) begin
               accx_in = accx_ff + ACC_W'(prodx_ff);
               accy_in = accy_ff + ACC_W'(prody_ff);
            end
            if (!issue && !rv_ff && !pv_ff) begin
               state_in = S_DIVLOAD;
            end
         end
         S_DIVLOAD: begin
            // keep the signs; the divide works on magnitudes
            negx_in  = accx_ff[ACC_W-1];
            negy_in  = accy_ff[ACC_W-1];
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // reciprocal estimate, remainder, then one correction
            step_in = step_ff + STEP_W'(1);
            case (step_ff)
               STEP_W'(0): begin
                  quox_in = recx[N_W +: COORD_W];
                  quoy_in = recy[N_W +: COORD_W];
               end
               STEP_W'(1): begin
                  remx_in = diffx[REM_W-1:0];
                  remy_in = diffy[REM_W-1:0];
               end
               default: begin
                  quox_in  = quox_ff + COORD_W'(remx_ff >= REM_W'(DIV_D));
                  quoy_in  = quoy_ff + COORD_W'(remy_ff >= REM_W'(DIV_D));
                  state_in = S_DONE;
               end
            endcase
         end
         S_DONE: begin
            // hand over to the output register once it is free
            if (out_free) begin
               if (primed_ff) begin
                  curx_in = negx_ff ? -$signed(quox_ff) : $signed(quox_ff);
                  cury_in = negy_ff ? -$signed(quoy_ff) : $signed(quoy_ff);
                  prvx_in = curx_ff;
                  prvy_in = cury_ff;
               end else begin
                  curx_in = px_ff;
                  cury_in = py_ff;
                  prvx_in = px_ff;
                  prvy_in = py_ff;
               end
               primed_in    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         primed_ff    <= 1'b0;
         slot_ff      <= '0;
         addr_ff      <= '0;
         cnt_ff       <= '0;
         rv_ff        <= 1'b0;
         pv_ff        <= 1'b0;
         widx_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         curx_ff      <= '0;
         cury_ff      <= '0;
         prvx_ff      <= '0;
         prvy_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         slot_ff      <= slot_in;
         addr_ff      <= addr_in;
         cnt_ff       <= cnt_in;
         rv_ff        <= rv_in;
         pv_ff        <= pv_in;
         widx_ff      <= widx_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         curx_ff      <= curx_in;
         cury_ff      <= cury_in;
         prvx_ff      <= prvx_in;
         prvy_ff      <= prvy_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      prodx_ff <= prodx_in;
      prody_ff <= prody_in;
      accx_ff  <= accx_in;
      accy_ff  <= accy_in;
      negx_ff  <= negx_in;
      negy_ff  <= negy_in;
      remx_ff  <= remx_in;
      remy_ff  <= remy_in;
      quox_ff  <= quox_in;
      quoy_ff  <= quoy_in;
   end

   // History RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_ram[mem_waddr] <= {py_ff, px_ff};
      end
      rdata_ff <= hist_ram[addr_ff];
   end

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bound_left_ff   <= '0;
         bound_right_ff  <= '0;
         bound_top_ff    <= '0;
         bound_bottom_ff <= '0;
         view_width_ff   <= '0;
         view_height_ff  <= '0;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            REG_BOUND_LEFT:   bound_left_ff   <= csr_port.data[PIX_W-1:0];
            REG_BOUND_RIGHT:  bound_right_ff  <= csr_port.data[PIX_W-1:0];
            REG_BOUND_TOP:    bound_top_ff    <= csr_port.data[PIX_W-1:0];
            REG_BOUND_BOTTOM: bound_bottom_ff <= csr_port.data[PIX_W-1:0];
            REG_VIEW_WIDTH:   view_width_ff   <= csr_port.data[VIEW_W-1:0];
            REG_VIEW_HEIGHT:  view_height_ff  <= csr_port.data[VIEW_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== tb/csm_checker.sv =====
// Checker for the clamped position smoother: request tracking, smoothing prediction, response compare.
module csm_checker
   import csm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   csm_req_if          req_mon,
   csm_rsp_if          rsp_mon,
   csm_csr_if          csr_mon,
   output int unsigned pending,
   output int unsigned fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = HISTORY_DEPTH_DEF;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      coord_type center_x;
      coord_type center_y;
      coord_type previous_x;
      coord_type previous_y;
   } smoothed_type;

   // Shadow of the block state
   point_type                track_hist [DEPTH];
   logic [$clog2(DEPTH)-1:0] head_slot;
   logic                     primed;
   point_type                now_pos;
   point_type                last_pos;

   // Shadow of the bound and view registers
   pix_type  lim_left, lim_right, lim_top, lim_bottom;
   view_type view_w, view_h;

   smoothed_type smoothed_q [$];
   int unsigned  misses;

   // Per-axis clamp; narrow or reversed bounds pin to the floored midpoint
   function automatic coord_type clamp_to_window(input coord_type v, input pix_type lo,
                                                 input pix_type hi, input view_type span);
      longint l, h, w, a, b, r;
      l = longint'(lo);
      h = longint'(hi);
      w = longint'(span);
      if (h - l <= w) begin
         r = ((l + h) >>> 1) * 256;
      end else begin
         a = (l + w / 2) * 256;
         b = (h - (w - w / 2)) * 256;
         r = longint'(v);
         if (r < a) r = a;
         else if (r > b) r = b;
      end
      return coord_type'(r);
   endfunction

   // Divide with round to nearest, ties away from zero
   function automatic coord_type mean_of(input longint acc, input longint total);
      longint mag, q;
      mag = (acc < 0) ? -acc : acc;
      q   = (2 * mag + total) / (2 * total);
      return coord_type'((acc < 0) ? -q : q);
   endfunction

   // Push one clamped point and produce the new/previous smoothed pair
   function automatic smoothed_type smooth_step(input point_type p);
      longint       acc_x, acc_y, wsum, wt;
      point_type    h;
      smoothed_type r;
      acc_x = 0;
      acc_y = 0;
      wsum  = 0;
      if (!primed) begin
         // first request fills the whole history
         for (int i = 0; i < DEPTH; i++) track_hist[i] = p;
         head_slot = '0;
         primed    = 1'b1;
         now_pos   = p;
         last_pos  = p;
      end else begin
         head_slot             = head_slot - 1'b1;
         track_hist[head_slot] = p;
         for (int i = 0; i < DEPTH; i++) begin
            wt    = (i + 1 > DEPTH - i) ? i + 1 : DEPTH - i;
            h     = track_hist[(head_slot + i) % DEPTH];
            acc_x += wt * longint'(h.x);
            acc_y += wt * longint'(h.y);
            wsum  += wt;
         end
         last_pos  = now_pos;
         now_pos.x = mean_of(acc_x, wsum);
         now_pos.y = mean_of(acc_y, wsum);
      end
      r.center_x   = now_pos.x;
      r.center_y   = now_pos.y;
      r.previous_x = last_pos.x;
      r.previous_y = last_pos.y;
      return r;
   endfunction

   function automatic void note_failure(input string msg);
      if (misses < MAX_REPORTS) $display("%0t ns: %s", $time, msg);
      misses++;
   endfunction

   function automatic void check_field(input string name, input coord_type want,
                                       input coord_type got);
      if (got !== want)
         note_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
   endfunction

   always @(posedge clock) begin
      smoothed_type want;
      point_type    p;
      if (reset) begin
         head_slot  = '0;
         primed     = 1'b0;
         now_pos    = '0;
         last_pos   = '0;
         lim_left   = '0;
         lim_right  = '0;
         lim_top    = '0;
         lim_bottom = '0;
         view_w     = '0;
         view_h     = '0;
         smoothed_q.delete();
      end else begin
         // response: compare against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (smoothed_q.size() == 0) begin
               note_failure($sformatf("response with nothing pending: center (%0d,%0d)",
                                      rsp_mon.center_x, rsp_mon.center_y));
            end else begin
               want = smoothed_q.pop_front();
               check_field("center_x", want.center_x, rsp_mon.center_x);
               check_field("center_y", want.center_y, rsp_mon.center_y);
               check_field("previous_x", want.previous_x, rsp_mon.previous_x);
               check_field("previous_y", want.previous_y, rsp_mon.previous_y);
            end
         end

         // request: clamp and predict
         if (req_mon.valid && req_mon.ready) begin
            p.x = clamp_to_window(req_mon.target_x, lim_left, lim_right, view_w);
            p.y = clamp_to_window(req_mon.target_y, lim_top, lim_bottom, view_h);
            smoothed_q.push_back(smooth_step(p));
         end

         // register writes; unused indexes are ignored
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_BOUND_LEFT:   lim_left   = pix_type'(csr_mon.data);
               REG_BOUND_RIGHT:  lim_right  = pix_type'(csr_mon.data);
               REG_BOUND_TOP:    lim_top    = pix_type'(csr_mon.data);
               REG_BOUND_BOTTOM: lim_bottom = pix_type'(csr_mon.data);
               REG_VIEW_WIDTH:   view_w     = view_type'(csr_mon.data);
               REG_VIEW_HEIGHT:  view_h     = view_type'(csr_mon.data);
               default: ;
            endcase
         end
      end
      pending    <= smoothed_q.size();
      fail_count <= misses;
   end

endmodule

// ===== tb/tb_clamped_position_smoother_unit.sv =====
// Testbench top for the clamped position smoother: clock, reset, stimulus and verdict.
module tb_clamped_position_smoother_unit
   import csm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 225;
   localparam int SQUEEZE_ITEMS   = 30;
   localparam int DRAIN_CYCLES    = HISTORY_DEPTH_DEF + 40;
   localparam int PIX_MIN         = -32768;
   localparam int PIX_MAX         = 32767;
   localparam int VIEW_MAX        = 32767;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;

   localparam coord_type COORD_MIN = coord_type'(-8388608);
   localparam coord_type COORD_MAX = coord_type'(8388607);

   logic        clock = 1'b0;
   logic        reset;
   logic        squeeze_go = 1'b0;
   int unsigned pending;
   int unsigned fail_count;

   // pixel span of the current bounds, used to aim targets
   int win_x_lo, win_x_hi, win_y_lo, win_y_hi;

   csm_req_if req_ch ();
   csm_rsp_if rsp_ch ();
   csm_csr_if csr_ch ();

   clamped_position_smoother_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   csm_checker smoother_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_mon    (csr_ch),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always #6 clock = ~clock;

   // Watchdog
   initial begin
      #60_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Idle lengths: mostly short, a few long
   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 8);
      return $urandom_range(30, 200);
   endfunction

   function automatic int stall_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 30);
      return $urandom_range(60, 250);
   endfunction

   function automatic int burst_len();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 40);
      return $urandom_range(150, 600);
   endfunction

   // Target coordinate: full random, extremes, or near the bounds
   function automatic coord_type pick_coord(input int lo_px, input int hi_px);
      int     roll;
      longint a, b, v;
      roll = $urandom_range(0, 99);
      a    = ((lo_px < hi_px) ? lo_px : hi_px) - 4;
      b    = ((lo_px < hi_px) ? hi_px : lo_px) + 4;
      if (roll < 30) return coord_type'($urandom);
      if (roll < 38) begin
         case ($urandom_range(0, 3))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            default: return coord_type'(-1);
         endcase
      end
      v = (a + longint'($urandom_range(0, int'(b - a)))) * 256 + $urandom_range(0, 255);
      if (v > longint'(COORD_MAX)) v = longint'(COORD_MAX);
      if (v < longint'(COORD_MIN)) v = longint'(COORD_MIN);
      return coord_type'(v);
   endfunction

   // Random bounds and view for one axis
   task automatic pick_axis(output int lo, output int hi, output logic [CSR_DATA_W-1:0] word);
      int view;
      lo = $urandom_range(0, 65535) + PIX_MIN;
      case ($urandom_range(0, 4))
         0: begin
            // full range
            lo   = PIX_MIN;
            hi   = PIX_MAX;
            view = $urandom_range(0, 1) ? VIEW_MAX : 0;
         end
         1: begin
            // wide, moderate span
            hi   = lo + $urandom_range(1, 4000);
            if (hi > PIX_MAX) hi = PIX_MAX;
            view = (hi - lo > 1) ? $urandom_range(0, hi - lo - 1) : 0;
         end
         2: begin
            // narrow: bounds no wider than the view
            hi   = lo + $urandom_range(0, 64);
            if (hi > PIX_MAX) hi = PIX_MAX;
            view = hi - lo + $urandom_range(0, 100);
         end
         3: begin
            // reversed bounds
            hi   = lo - $urandom_range(1, 500);
            if (hi < PIX_MIN) hi = PIX_MIN;
            view = $urandom_range(0, VIEW_MAX);
         end
         default: begin
            hi   = $urandom_range(0, 65535) + PIX_MIN;
            view = $urandom_range(0, VIEW_MAX);
         end
      endcase
      // bit 15 of the view word is random and must be dropped
      word = {1'($urandom), 15'(view)};
   endtask

   // One register write request; valid stays high for the next one
   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic program_window(input int left, input int right, input int top,
                                 input int bottom, input logic [CSR_DATA_W-1:0] width_word,
                                 input logic [CSR_DATA_W-1:0] height_word,
                                 input bit touch_spare);
      put_reg(REG_BOUND_LEFT, 16'(left));
      put_reg(REG_BOUND_RIGHT, 16'(right));
      put_reg(REG_BOUND_TOP, 16'(top));
      put_reg(REG_BOUND_BOTTOM, 16'(bottom));
      put_reg(REG_VIEW_WIDTH, width_word);
      put_reg(REG_VIEW_HEIGHT, height_word);
      if (touch_spare) begin
         put_reg(REG_SPARE_A, 16'($urandom));
         put_reg(REG_SPARE_B, 16'($urandom));
      end
      csr_ch.valid <= 1'b0;
      win_x_lo = left;
      win_x_hi = right;
      win_y_lo = top;
      win_y_hi = bottom;
   endtask

   task automatic random_window();
      int                    xl, xh, yl, yh;
      logic [CSR_DATA_W-1:0] ww, hw;
      pick_axis(xl, xh, ww);
      pick_axis(yl, yh, hw);
      program_window(xl, xh, yl, yh, ww, hw, $urandom_range(0, 1));
   endtask

   // One position request, then an optional idle gap
   task automatic send_target(input coord_type tx, input coord_type ty, input bit eager);
      int gap;
      gap = eager ? 0 : gap_len();
      req_ch.valid    <= 1'b1;
      req_ch.target_x <= tx;
      req_ch.target_y <= ty;
      do @(posedge clock); while (!req_ch.ready);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait for every pending response
   task automatic finish_phase();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Response side: random ready, plus one long hold-off on request
   initial begin
      bit held_off;
      held_off = 1'b0;
      forever begin
         if (squeeze_go && !held_off) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            held_off = 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat (burst_len()) @(posedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (stall_len()) @(posedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.target_x <= '0;
      req_ch.target_y <= '0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= '0;
      csr_ch.data     <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // full bounds, zero view; first request primes the history
      program_window(PIX_MIN, PIX_MAX, PIX_MIN, PIX_MAX, 16'h0000, 16'h0000, 1'b0);
      send_target(COORD_MAX, COORD_MIN, 1'b0);
      send_target(COORD_MIN, COORD_MAX, 1'b0);
      send_target('0, '0, 1'b0);
      send_target(coord_type'(-1), coord_type'(1), 1'b0);
      send_target(coord_type'(255), coord_type'(-256), 1'b0);
      send_target(COORD_MAX, COORD_MAX, 1'b0);
      send_target(COORD_MIN, COORD_MIN, 1'b0);
      send_target(coord_type'(24'h123456), coord_type'(-24'sh123456), 1'b0);
      finish_phase();

      // full bounds, largest view
      program_window(PIX_MIN, PIX_MAX, PIX_MIN, PIX_MAX, 16'h7FFF, 16'h7FFF, 1'b0);
      send_target(COORD_MAX, COORD_MIN, 1'b0);
      send_target(COORD_MIN, COORD_MAX, 1'b0);
      send_target('0, coord_type'(-1), 1'b0);
      finish_phase();

      // narrow x with negative odd midpoint, reversed y
      program_window(-3, 0, 100, -100, 16'd3, 16'd0, 1'b0);
      send_target(COORD_MAX, COORD_MAX, 1'b0);
      send_target(COORD_MIN, COORD_MIN, 1'b0);
      send_target(coord_type'(-1), '0, 1'b0);
      finish_phase();

      // narrow x with dropped view bit, y pinned at the lowest pixel, unused indexes
      program_window(5, 8, PIX_MIN, PIX_MIN, 16'h8003, 16'hFFFF, 1'b1);
      send_target('0, COORD_MAX, 1'b0);
      send_target(COORD_MIN, '0, 1'b0);
      send_target(COORD_MAX, COORD_MIN, 1'b0);
      finish_phase();

      // x bounds one pixel wider than the view
      program_window(0, 11, PIX_MIN, PIX_MAX, 16'd10, 16'd1, 1'b0);
      send_target(coord_type'(1279), coord_type'(8388352), 1'b0);
      send_target(coord_type'(1537), coord_type'(8388353), 1'b0);
      send_target(coord_type'(1400), COORD_MIN, 1'b0);
      send_target('0, '0, 1'b0);
      finish_phase();

      // back-to-back requests while the response side holds off
      random_window();
      squeeze_go <= 1'b1;
      repeat (SQUEEZE_ITEMS)
         send_target(pick_coord(win_x_lo, win_x_hi), pick_coord(win_y_lo, win_y_hi), 1'b1);
      finish_phase();

      // random phases, each with fresh bounds and view
      repeat (RANDOM_PHASES) begin
         random_window();
         repeat (ITEMS_PER_PHASE)
            send_target(pick_coord(win_x_lo, win_x_hi), pick_coord(win_y_lo, win_y_hi), 1'b0);
         finish_phase();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/csm_pkg.sv
design/csm_req_if.sv
design/csm_rsp_if.sv
design/csm_csr_if.sv
design/clamped_position_smoother_unit.sv
tb/csm_checker.sv
tb/tb_clamped_position_smoother_unit.sv
